FILE: hdl/rme_pkg.sv
// Package for the rotation matrix to Euler angle converter.
// Holds the CORDIC angle table and pipeline constants.
// No dependencies.
package rme_pkg;

	localparam int CORDIC_STEPS = 20;
	localparam int SQRT_STEPS   = 17;
	localparam int ANG_MAX      = 25736;
	localparam int PI_UNITS     = 3294199;

	// CORDIC datapath width: 17-bit operand times 4096, growth, sign.
	localparam int CW = 34;
	// Angle accumulator width in units of 2^-20 rad.
	localparam int ZW = 24;

	typedef logic signed [CW-1:0] cval_t;
	typedef logic signed [ZW-1:0] zval_t;

	// Rounded atan(2^-i) table in units of 2^-20 rad.
	function automatic zval_t atan_tab(input int i);
		zval_t r;
		case (i)
			0:  r = 24'sd823550;
			1:  r = 24'sd486170;
			2:  r = 24'sd256879;
			3:  r = 24'sd130396;
			4:  r = 24'sd65451;
			5:  r = 24'sd32757;
			6:  r = 24'sd16383;
			7:  r = 24'sd8192;
			8:  r = 24'sd4096;
			9:  r = 24'sd2048;
			10: r = 24'sd1024;
			11: r = 24'sd512;
			12: r = 24'sd256;
			13: r = 24'sd128;
			14: r = 24'sd64;
			15: r = 24'sd32;
			16: r = 24'sd16;
			17: r = 24'sd8;
			18: r = 24'sd4;
			19: r = 24'sd2;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

FILE: hdl/rme_cordic.sv
// Pipelined vectoring CORDIC computing atan2(y, x) to Q3.13, one stage per iteration.
// Depends on rme_pkg.
module rme_cordic
	import rme_pkg::*;
(
	input  logic               clk,
	input  logic               en,
	input  logic signed [17:0] y_in,
	input  logic signed [17:0] x_in,
	output logic signed [15:0] ang
);

	cval_t x_s [CORDIC_STEPS+1];
	cval_t y_s [CORDIC_STEPS+1];
	zval_t z_s [CORDIC_STEPS+1];
	logic  d_s [CORDIC_STEPS+1];
	zval_t zr;
	logic signed [ZW-8:0] q;

	// Input stage: fold the left half-plane, scale by 4096, flag zero vector.
	always_ff @(posedge clk) begin
		if (en) begin
			if (x_in < 0) begin
				x_s[0] <= cval_t'(-x_in) <<< 12;
				y_s[0] <= cval_t'(-y_in) <<< 12;
				z_s[0] <= (y_in >= 0) ? zval_t'(PI_UNITS) : -zval_t'(PI_UNITS);
			end else begin
				x_s[0] <= cval_t'(x_in) <<< 12;
				y_s[0] <= cval_t'(y_in) <<< 12;
				z_s[0] <= '0;
			end
			d_s[0] <= (x_in == 0) && (y_in == 0);
		end
	end

	// One iteration per stage; a zero y stops further rotation.
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_it
		always_ff @(posedge clk) begin
			if (en) begin
				d_s[i+1] <= d_s[i];
				if (y_s[i] > 0) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + atan_tab(i);
				end else if (y_s[i] < 0) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - atan_tab(i);
				end else begin
					x_s[i+1] <= x_s[i];
					y_s[i+1] <= y_s[i];
					z_s[i+1] <= z_s[i];
				end
			end
		end
	end

	// Round to Q3.13 and saturate; a zero vector gives zero.
	always_comb begin
		zr = z_s[CORDIC_STEPS] + zval_t'(64);
		q  = zr[ZW-1:7];
		if (d_s[CORDIC_STEPS])
			ang = '0;
		else if (q > ANG_MAX)
			ang = 16'sd25736;
		else if (q < -ANG_MAX)
			ang = -16'sd25736;
		else
			ang = q[15:0];
	end

endmodule

FILE: hdl/rotation_matrix_to_euler.sv
// Rotation matrix to Euler angles: bit-serial pipelined square root and three CORDICs.
// Pipeline: 18 root stages (operand register and 17 bit stages), 21 CORDIC stages and
// one output register.
// Throughput: one matrix per cycle; the whole pipeline advances when output is free.
// Reset: arst_n clears valid bits and sets the threshold to 1; payload is not reset.
// Depends on rme_pkg and rme_cordic.
module rotation_matrix_to_euler
	import rme_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [14:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [111:0] s_tdata,  // r00, r10, r11, r12, r20, r21, r22 (16 bits each)
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [47:0]  m_tdata,  // roll, pitch, yaw (16 bits each)
	output logic         m_tuser   // singular
);

	localparam int LAT = SQRT_STEPS + CORDIC_STEPS + 3;

	logic [14:0] thr_q;
	logic        en;
	logic [LAT-1:0] vld_q;

	// Threshold register.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) thr_q <= 15'd1;
		else if (cfg_valid) thr_q <= cfg_data;
	end

	// Pipeline advances unless the output holds an untaken transfer.
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[LAT-2:0], s_tvalid};
	end

	// Square root: restoring, one result bit per stage, operands carried along.
	logic [33:0]  rem_s [SQRT_STEPS+1];
	logic [16:0]  rt_s  [SQRT_STEPS+1];
	logic [111:0] d_s   [SQRT_STEPS+1];
	logic signed [15:0] a0, a1;
	assign a0 = s_tdata[15:0];
	assign a1 = s_tdata[31:16];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= 34'(a0 * a0) + 34'(a1 * a1);
			rt_s[0]  <= '0;
			d_s[0]   <= s_tdata;
		end
	end

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sq
		localparam int B = SQRT_STEPS - 1 - k;
		logic [16:0] trial;
		logic [33:0] sq;
		assign trial = rt_s[k] | (17'd1 << B);
		assign sq    = 34'(trial) * 34'(trial);
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= rem_s[k];
				rt_s[k+1]  <= (sq <= rem_s[k]) ? trial : rt_s[k];
				d_s[k+1]   <= d_s[k];
			end
		end
	end

	// Branch select and CORDIC operands.
	logic [16:0] sy;
	logic        sing;
	logic signed [15:0] r00, r10, r11, r12, r20, r21, r22;
	assign sy   = rt_s[SQRT_STEPS];
	assign sing = sy < {2'b0, thr_q};
	assign {r22, r21, r20, r12, r11, r10, r00} = d_s[SQRT_STEPS];

	logic signed [17:0] ry, rx, py, px, yy, yx;
	assign ry = sing ? -18'(r12) : 18'(r21);
	assign rx = sing ?  18'(r11) : 18'(r22);
	assign py = -18'(r20);
	assign px = 18'($signed({1'b0, sy}));
	assign yy = sing ? 18'sd0 : 18'(r10);
	assign yx = sing ? 18'sd0 : 18'(r00);

	logic [CORDIC_STEPS:0] sg_q;
	always_ff @(posedge clk) begin
		if (en) sg_q <= {sg_q[CORDIC_STEPS-1:0], sing};
	end

	logic signed [15:0] roll, pitch, yaw;
	rme_cordic u_roll  (.clk, .en, .y_in(ry), .x_in(rx), .ang(roll));
	rme_cordic u_pitch (.clk, .en, .y_in(py), .x_in(px), .ang(pitch));
	rme_cordic u_yaw   (.clk, .en, .y_in(yy), .x_in(yx), .ang(yaw));

	// Output register.
	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= {yaw, pitch, roll};
			m_tuser <= sg_q[CORDIC_STEPS];
		end
	end
	assign m_tvalid = vld_q[LAT-1];

endmodule

FILE: hdl/rme_checker.sv
// Port-level checker for rotation_matrix_to_euler, bound to the top level.
// Depends on rme_pkg.
module rme_checker
	import rme_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic        m_tuser
);

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");

	// Input is taken whenever output is free.
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready) else $error("needless input stall");

	// Yaw is zero on singular results.
	a_yaw: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[47:32] == 16'd0) else $error("yaw not zero");

	// Roll stays within plus or minus pi.
	a_rng: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $signed(m_tdata[15:0]) <= ANG_MAX && $signed(m_tdata[15:0]) >= -ANG_MAX)
		else $error("roll out of range");

endmodule

bind rotation_matrix_to_euler rme_checker u_chk (.*);

FILE: test/tb_rotation_matrix_to_euler.sv
// Testbench for the rotation matrix to Euler angle converter.
// Predicts roll, pitch, yaw and the singular flag for each matrix and checks every result.
// Depends on rme_pkg and the rotation_matrix_to_euler RTL.
`timescale 1ns / 1ps

module tb_rotation_matrix_to_euler;
	import rme_pkg::*;

	localparam int LATENCY = 40;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic signed [15:0] r22, r21, r20, r12, r11, r10, r00;
	} matrix_t;

	typedef struct {
		logic [15:0] roll, pitch, yaw;
		logic singular;
	} angles_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [14:0]  cfg_data = '0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [111:0] s_tdata = '0;  // r00, r10, r11, r12, r20, r21, r22 (16 bits each)
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [47:0]  m_tdata;       // roll, pitch, yaw (16 bits each)
	logic         m_tuser;       // singular

	angles_t expected_angles[$];
	int unsigned threshold_q14;
	int mismatch_count = 0;
	longint cycle_count = 0;
	int hold_cycles = 0;
	bit drain_done = 1'b0;

	rotation_matrix_to_euler dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always #1 clk = ~clk;

	// Arithmetic right shift, rounding toward minus infinity.
	function automatic longint shift_down(longint v, int s);
		return v >>> s;
	endfunction

	// Integer square root, bit by bit.
	function automatic longint int_sqrt(longint n);
		longint root, bitv;
		root = 0;
		bitv = 64'sd1 <<< 40;
		while (bitv > n) bitv = bitv >>> 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n = n - (root + bitv);
				root = (root >>> 1) + bitv;
			end else begin
				root = root >>> 1;
			end
			bitv = bitv >>> 2;
		end
		return root;
	endfunction

	// Vectoring CORDIC arctangent, result in Q3.13 radians.
	function automatic logic [15:0] cordic_atan2(longint y, longint x);
		longint z, nx, ny, q;
		z = 0;
		if (x == 0 && y == 0) return 16'd0;
		if (x < 0) begin
			z = (y >= 0) ? PI_UNITS : -PI_UNITS;
			x = -x;
			y = -y;
		end
		x = x * 4096;
		y = y * 4096;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			if (y == 0) break;
			if (y > 0) begin
				nx = x + shift_down(y, i);
				ny = y - shift_down(x, i);
				z = z + longint'(atan_tab(i));
			end else begin
				nx = x - shift_down(y, i);
				ny = y + shift_down(x, i);
				z = z - longint'(atan_tab(i));
			end
			x = nx;
			y = ny;
		end
		q = shift_down(z + 64, 7);
		if (q > ANG_MAX) q = ANG_MAX;
		if (q < -ANG_MAX) q = -ANG_MAX;
		return q[15:0];
	endfunction

	function automatic angles_t euler_angles(matrix_t m);
		angles_t a;
		longint sy;
		sy = int_sqrt(longint'(m.r00) * m.r00 + longint'(m.r10) * m.r10);
		a.singular = sy < threshold_q14;
		a.pitch = cordic_atan2(-longint'(m.r20), sy);
		if (!a.singular) begin
			a.roll = cordic_atan2(m.r21, m.r22);
			a.yaw = cordic_atan2(m.r10, m.r00);
		end else begin
			a.roll = cordic_atan2(-longint'(m.r12), m.r11);
			a.yaw = 16'd0;
		end
		return a;
	endfunction

	task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
		$display("mismatch on %s: got %0d, expected %0d at cycle %0d",
			what, $signed(got), $signed(want), cycle_count);
		mismatch_count++;
	endtask

	// Sends one matrix after a random gap and records its expected angles.
	// Valid stays high after the transfer so a zero gap follows back to back.
	task automatic send_matrix(matrix_t m);
		int gap;
		gap = $urandom_range(0, 11);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= m;
		do @(posedge clk); while (!s_tready);
		expected_angles.push_back(euler_angles(m));
	endtask

	task automatic write_threshold(logic [14:0] value);
		s_tvalid <= 1'b0;
		while (expected_angles.size() != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		threshold_q14 = value;
	endtask

	function automatic logic signed [15:0] any_entry();
		case ($urandom_range(0, 5))
			0: return 16'sd16384;
			1: return -16'sd16384;
			2: return 16'sd0;
			3: return 16'($urandom);
			default: return 16'($signed($urandom_range(0, 32768)) - 16384);
		endcase
	endfunction

	function automatic matrix_t random_matrix(int scale);
		matrix_t m;
		m = {any_entry(), any_entry(), any_entry(), any_entry(), any_entry(), any_entry(),
			any_entry()};
		// Near gimbal lock: shrink the first column's top two entries.
		if (scale > 0) begin
			m.r00 = $signed(m.r00) >>> scale;
			m.r10 = $signed(m.r10) >>> scale;
		end
		return m;
	endfunction

	task automatic test_directed();
		matrix_t m;
		send_matrix('0);
		send_matrix({7{16'sd16384}});
		send_matrix({7{-16'sd16384}});
		send_matrix({7{16'h7FFF}});
		send_matrix({7{16'h8000}});
		send_matrix({7{16'hFFFF}});
		// Identity and the identity with its first two axes negated.
		m = '0; m.r00 = 16'sd16384; m.r11 = 16'sd16384; m.r22 = 16'sd16384; send_matrix(m);
		m = '0; m.r00 = -16'sd16384; m.r11 = -16'sd16384; m.r22 = 16'sd16384; send_matrix(m);
		// Gimbal lock with pitch at plus and minus a quarter turn.
		m = '0; m.r20 = -16'sd16384; m.r11 = 16'sd16384; m.r12 = -16'sd16384; send_matrix(m);
		m = '0; m.r20 = 16'sd16384; m.r11 = -16'sd16384; m.r12 = 16'sd16384; send_matrix(m);
		// Negative x with zero and negative y, then zero x with positive y.
		m = '0; m.r00 = -16'sd100; m.r22 = -16'sd5; m.r21 = -16'sd1; send_matrix(m);
		m = '0; m.r00 = -16'sd100; m.r10 = 16'sd0; m.r22 = -16'sd5; send_matrix(m);
		m = '0; m.r10 = 16'sd1; m.r21 = 16'sd1; send_matrix(m);
	endtask

	task automatic test_threshold_sweep();
		logic [14:0] settings[5] = '{15'd0, 15'd23170, 15'd16384, 15'd200, 15'h7FFF};
		foreach (settings[k]) begin
			write_threshold(settings[k]);
			repeat (40) send_matrix(random_matrix($urandom_range(0, 16)));
		end
	endtask

	task automatic test_random();
		write_threshold(15'($urandom_range(0, 23170)));
		repeat (500) send_matrix(random_matrix($urandom_range(0, 3) == 0 ?
			$urandom_range(1, 16) : 0));
	endtask

	// Back-to-back matrices while the receiver holds off.
	task automatic test_backpressure();
		hold_cycles = 150;
		repeat (60) begin
			s_tvalid <= 1'b1;
			s_tdata <= random_matrix(0);
			do @(posedge clk); while (!s_tready);
			expected_angles.push_back(euler_angles(matrix_t'(s_tdata)));
		end
		s_tvalid <= 1'b0;
	endtask

	// Receiver: random stalls, with a long hold-off when requested.
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 11) < 8);
		end
	end

	// Check each accepted result against the oldest expectation.
	always @(posedge clk) begin
		angles_t want;
		cycle_count <= cycle_count + 1;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_angles.size() == 0) begin
				$display("unexpected result at cycle %0d", cycle_count);
				mismatch_count++;
			end else begin
				want = expected_angles.pop_front();
				if (m_tdata[15:0] !== want.roll) report_mismatch("roll", m_tdata[15:0], want.roll);
				if (m_tdata[31:16] !== want.pitch)
					report_mismatch("pitch", m_tdata[31:16], want.pitch);
				if (m_tdata[47:32] !== want.yaw) report_mismatch("yaw", m_tdata[47:32], want.yaw);
				if (m_tuser !== want.singular)
					report_mismatch("singular", 16'(m_tuser), 16'(want.singular));
			end
		end
		if (cycle_count > CYCLE_LIMIT && !drain_done) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		threshold_q14 = 1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_threshold_sweep();
		test_backpressure();
		test_random();
		s_tvalid <= 1'b0;
		while (expected_angles.size() != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
		drain_done = 1'b1;
		if (mismatch_count == 0 && expected_angles.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
